FILE: hw/rtl/sqtr_pkg.sv
package sqtr_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;
    localparam int unsigned CODE_W              = 8;
    localparam int unsigned DELAY_W             = 8;
    localparam int unsigned NUM_NO_REPEAT       = 8;

    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [DELAY_W-1:0] delay_t;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    localparam logic CFG_FIRST_DELAY = 1'b0;
    localparam logic CFG_NEXT_DELAY  = 1'b1;

    localparam delay_t FIRST_DELAY_RESET = 8'd15;
    localparam delay_t NEXT_DELAY_RESET  = 8'd2;

    localparam code_t NO_REPEAT_CODES [NUM_NO_REPEAT] = '{
        8'h3A, 8'h54, 8'h46, 8'h45, 8'h1D, 8'h38, 8'h2A, 8'h36
    };

    // lock and modifier keys do not auto-repeat
    function automatic logic is_repeating(input code_t c);
        logic rep;
        rep = 1'b1;
        for (int i = 0; i < NUM_NO_REPEAT; i++) begin
            if (c == NO_REPEAT_CODES[i]) begin
                rep = 1'b0;
            end
        end
        return rep;
    endfunction

endpackage

FILE: hw/rtl/scancode_queue_typematic_repeat.sv
// Channel  | Dir | Ports                                   | Contents
// ---------+-----+-----------------------------------------+------------------------------
// input    | in  | s_tvalid s_tready s_tdata s_tuser       | tdata: code; tuser: mode
// result   | out | m_tvalid m_tready m_tdata               | tdata: scancode
// config   | in  | cfg_wr_en cfg_index cfg_wdata           | 0 first delay, 1 next delay
//
// One input transfer per cycle while s_tready is high; the state updates at the
// accepting edge and a result is loaded into the output or skid register.
// The queue is a RAM with a registered head word refreshed at every edge.
// A two-deep output stage (output register plus skid) keeps s_tready off m_tready.
// Reset is synchronous and clears control state; queue contents stay undefined.
module scancode_queue_typematic_repeat
    import sqtr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] code
    input  logic [1:0]        s_tuser,   // [1:0] mode

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] scancode

    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_wdata
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    code_t            queue_mem [QUEUE_DEPTH];
    code_t            head_reg;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    code_t  held_key_reg, held_key_next;
    logic   repeat_en_reg, repeat_en_next;
    delay_t countdown_reg, countdown_next;
    delay_t first_delay_reg;
    delay_t next_delay_reg;

    logic   out_valid_reg;
    code_t  out_data_reg;
    logic   skid_valid_reg;
    code_t  skid_data_reg;

    logic   accept;
    logic   push_wr;
    code_t  tick_code;
    delay_t countdown_dec;
    logic   emit;
    logic   res_valid;
    logic   out_load;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign tick_code     = (count_reg == '0) ? held_key_reg : head_reg;
    assign countdown_dec = (countdown_reg != '0) ? countdown_reg - 8'd1 : countdown_reg;

    always_comb begin
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        count_next     = count_reg;
        held_key_next  = held_key_reg;
        repeat_en_next = repeat_en_reg;
        countdown_next = countdown_reg;
        push_wr        = 1'b0;
        emit           = 1'b0;
        if (accept) begin
            unique case (s_tuser)
                MODE_PUSH: begin
                    if (count_reg < CNT_FULL) begin
                        push_wr     = 1'b1;
                        wr_ptr_next = ptr_inc(wr_ptr_reg);
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                MODE_TICK: begin
                    if (count_reg != '0) begin
                        rd_ptr_next = ptr_inc(rd_ptr_reg);
                        count_next  = count_reg - CNT_W'(1);
                    end
                    if (tick_code != '0) begin
                        countdown_next = countdown_dec;
                        if (tick_code[7]) begin
                            // release
                            if ({1'b0, tick_code[6:0]} == held_key_reg) begin
                                held_key_next = '0;
                            end
                            emit = 1'b1;
                        end else if (tick_code != held_key_reg) begin
                            held_key_next  = tick_code;
                            repeat_en_next = is_repeating(tick_code);
                            if (repeat_en_next) begin
                                countdown_next = first_delay_reg;
                            end
                            emit = 1'b1;
                        end else if (repeat_en_reg && countdown_dec == '0) begin
                            countdown_next = next_delay_reg;
                            emit           = 1'b1;
                        end
                    end
                end
                MODE_CLEAR: begin
                    rd_ptr_next   = '0;
                    wr_ptr_next   = '0;
                    count_next    = '0;
                    held_key_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign res_valid = emit;
    assign out_load  = ~out_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            count_reg       <= '0;
            held_key_reg    <= '0;
            repeat_en_reg   <= 1'b0;
            countdown_reg   <= '0;
            first_delay_reg <= FIRST_DELAY_RESET;
            next_delay_reg  <= NEXT_DELAY_RESET;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            count_reg     <= count_next;
            held_key_reg  <= held_key_next;
            repeat_en_reg <= repeat_en_next;
            countdown_reg <= countdown_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_FIRST_DELAY: first_delay_reg <= cfg_wdata;
                    CFG_NEXT_DELAY:  next_delay_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                out_valid_reg  <= skid_valid_reg | res_valid;
                skid_valid_reg <= 1'b0;
            end else if (res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // payload: output and skid data
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : tick_code;
        end else if (res_valid) begin
            skid_data_reg <= tick_code;
        end
    end

    // queue RAM, head word read ahead with write bypass
    always_ff @(posedge aclk) begin
        if (push_wr) begin
            queue_mem[wr_ptr_reg] <= s_tdata;
        end
        if (push_wr && wr_ptr_reg == rd_ptr_next) begin
            head_reg <= s_tdata;
        end else begin
            head_reg <= queue_mem[rd_ptr_next];
        end
    end

endmodule
